// ===== src/path_element_token_parser_unit_assert.svh =====
// assertion macros for the path element token parser
// expects signals named clock and reset in the module that includes it
`ifndef PATH_ELEMENT_TOKEN_PARSER_UNIT_ASSERT_SVH
`define PATH_ELEMENT_TOKEN_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define PETP_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: lbl");

// next-cycle implication, quiet during reset
`define PETP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: lbl");

`endif

// ===== src/petp_pkg.sv =====
// shared types, codes and character class helpers for the path element parser
// no dependencies
package petp_pkg;

   localparam int IndexWidthDefault = 32;
   localparam int IdxOutWidth       = 32;

   // grammar state codes
   localparam logic [2:0] GS_START   = 3'd0;
   localparam logic [2:0] GS_PERCENT = 3'd1;
   localparam logic [2:0] GS_BODY    = 3'd2;
   localparam logic [2:0] GS_DOT     = 3'd3;
   localparam logic [2:0] GS_ARRAY   = 3'd4;
   localparam logic [2:0] GS_BASE    = 3'd5;
   localparam logic [2:0] GS_INDEX   = 3'd6;
   localparam logic [2:0] GS_DONE    = 3'd7;

   // index radix codes
   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_OCT = 2'd1;
   localparam logic [1:0] RADIX_HEX = 2'd2;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_beat_type;

   typedef struct packed {
      logic [7:0]             name_char;
      logic                   name_valid;
      logic                   done_res;
      logic                   has_array;
      logic                   index_given;
      logic [IdxOutWidth-1:0] index_value;
      logic                   parse_fail;
      logic                   overflow;
   } rsp_beat_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_octal(input logic [7:0] c);
      return c >= "0" && c <= "7";
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   // digit value, letters a-f and A-F give 10 to 15
   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      if (is_digit(c)) begin
         v = c - 8'h30;
      end else if (c >= "a" && c <= "f") begin
         v = c - 8'h57;
      end else begin
         v = c - 8'h37;
      end
      return v[3:0];
   endfunction

endpackage

// ===== src/path_element_token_parser_unit.sv =====
// path element token parser: grammar state, index accumulator, result register
// depends on petp_pkg and path_element_token_parser_unit_assert.svh
//
//   channel  | direction | payload
//   ---------+-----------+---------------------------------
//   req_     | in        | petp_pkg::req_beat_type (ch, last)
//   rsp_     | out       | petp_pkg::rsp_beat_type (8 fields)
//
// one character per clock while rsp_ready drains the output: each accepted beat
// updates the grammar state and index accumulator in the same cycle and lands its
// result in the output register, visible in the cycle after the beat is taken.
// the output register holds a result until rsp_ready; req_ready stays high
// whenever the register is empty or is being drained in that cycle.
// synchronous reset returns the parser to its start state with no result pending.
module path_element_token_parser_unit #(
   parameter int INDEX_WIDTH = petp_pkg::IndexWidthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  petp_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output petp_pkg::rsp_beat_type rsp_data
);
   import petp_pkg::*;

   `include "path_element_token_parser_unit_assert.svh"

   localparam int ExtWidth = INDEX_WIDTH + 5;

   // parser state
   logic [2:0]             gs_ff, gs_in;
   logic [1:0]             radix_ff, radix_in;
   logic [INDEX_WIDTH-1:0] acc_ff, acc_in;
   logic                   arr_ff, arr_in;
   logic                   idx_ff, idx_in;
   logic                   fail_ff, fail_in;
   logic                   sat_ff, sat_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_data_ff, rsp_data_in;

   logic accept;
   logic take;
   logic bad;

   // shared digit accumulate
   logic                   dig_do;
   logic [1:0]             dig_radix;
   logic [3:0]             dig_val;
   logic                   dig_fresh;
   logic [ExtWidth-1:0]    dig_base;
   logic [ExtWidth-1:0]    dig_prod;
   logic [ExtWidth-1:0]    dig_sum;
   logic                   dig_ovf;

   logic [7:0] c;

   // terms for the checks
   logic chk_mid_beat;
   logic chk_mid_clear;
   logic chk_last_taken;
   logic chk_state_start;

   assign c         = req_data.ch;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // grammar step for one character
   always_comb begin
      gs_in     = gs_ff;
      radix_in  = radix_ff;
      arr_in    = arr_ff;
      idx_in    = idx_ff;
      take      = 1'b0;
      bad       = 1'b0;
      dig_do    = 1'b0;
      dig_radix = radix_ff;
      dig_val   = 4'd0;
      dig_fresh = 1'b0;
      if (!fail_ff) begin
         unique case (gs_ff)
            GS_START: begin
               if (c == "%") begin
                  take  = 1'b1;
                  gs_in = GS_PERCENT;
               end else if (c == "^") begin
                  take  = 1'b1;
                  gs_in = GS_DONE;
               end else if (is_letter(c) || c == "_") begin
                  take  = 1'b1;
                  gs_in = GS_BODY;
               end else if (c == ".") begin
                  take  = 1'b1;
                  gs_in = GS_DOT;
               end else begin
                  bad = 1'b1;
               end
            end
            GS_PERCENT: begin
               if (is_letter(c) || c == "_") begin
                  take  = 1'b1;
                  gs_in = GS_BODY;
               end else begin
                  bad = 1'b1;
               end
            end
            GS_BODY: begin
               if (is_letter(c) || is_digit(c) || c == "_" || c == ".") begin
                  take = 1'b1;
               end else if (c == "[") begin
                  arr_in = 1'b1;
                  gs_in  = GS_ARRAY;
               end else begin
                  bad = 1'b1;
               end
            end
            GS_DOT: begin
               if (c == ".") begin
                  take  = 1'b1;
                  gs_in = GS_DONE;
               end else begin
                  bad = 1'b1;
               end
            end
            GS_ARRAY: begin
               if (c == "]") begin
                  idx_in = 1'b0;
                  gs_in  = GS_DONE;
               end else if (c == "0") begin
                  idx_in    = 1'b1;
                  dig_fresh = 1'b1;
                  gs_in     = GS_BASE;
               end else if (is_digit(c)) begin
                  idx_in    = 1'b1;
                  radix_in  = RADIX_DEC;
                  dig_fresh = 1'b1;
                  dig_do    = 1'b1;
                  dig_radix = RADIX_DEC;
                  dig_val   = hex_val(c);
                  gs_in     = GS_INDEX;
               end else begin
                  bad = 1'b1;
               end
            end
            GS_BASE: begin
               if (c == "x") begin
                  radix_in = RADIX_HEX;
                  gs_in    = GS_INDEX;
               end else if (is_octal(c)) begin
                  radix_in  = RADIX_OCT;
                  dig_do    = 1'b1;
                  dig_radix = RADIX_OCT;
                  dig_val   = hex_val(c);
                  gs_in     = GS_INDEX;
               end else if (c == "]") begin
                  radix_in = RADIX_DEC;
                  gs_in    = GS_DONE;
               end else begin
                  bad = 1'b1;
               end
            end
            GS_INDEX: begin
               if ((radix_ff == RADIX_DEC && is_digit(c))
                   || (radix_ff == RADIX_OCT && is_octal(c))
                   || (radix_ff == RADIX_HEX && is_hex(c))) begin
                  dig_do  = 1'b1;
                  dig_val = hex_val(c);
               end else if (c == "]") begin
                  gs_in = GS_DONE;
               end else begin
                  bad = 1'b1;
               end
            end
            GS_DONE: begin
               bad = 1'b1;
            end
            default: begin
               bad = 1'b1;
            end
         endcase
      end
   end

   // accumulate one digit: times 10, 8 or 16 by shifts, saturate on carry out
   always_comb begin
      dig_base = dig_fresh ? '0 : ExtWidth'(acc_ff);
      unique case (dig_radix)
         RADIX_OCT: dig_prod = dig_base << 3;
         RADIX_HEX: dig_prod = dig_base << 4;
         default:   dig_prod = (dig_base << 3) + (dig_base << 1);
      endcase
      dig_sum = dig_prod + ExtWidth'(dig_val);
      dig_ovf = |dig_sum[ExtWidth-1:INDEX_WIDTH];
   end

   // index and flag updates
   always_comb begin
      acc_in  = dig_fresh ? '0 : acc_ff;
      sat_in  = sat_ff;
      fail_in = fail_ff || bad;
      if (dig_do) begin
         if (dig_ovf) begin
            acc_in = '1;
            sat_in = 1'b1;
         end else begin
            acc_in = dig_sum[INDEX_WIDTH-1:0];
         end
      end
   end

   // result beat
   always_comb begin
      rsp_data_in.name_char   = c;
      rsp_data_in.name_valid  = take && !bad;
      rsp_data_in.done_res    = req_data.last;
      rsp_data_in.has_array   = req_data.last && arr_in;
      rsp_data_in.index_given = req_data.last && idx_in;
      rsp_data_in.index_value = (req_data.last && idx_in) ? IdxOutWidth'(acc_in) : '0;
      rsp_data_in.parse_fail  = req_data.last && fail_in;
      rsp_data_in.overflow    = req_data.last && sat_in;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state registers, cleared after each element's last character
   always_ff @(posedge clock) begin
      if (reset || (accept && req_data.last)) begin
         gs_ff    <= GS_START;
         radix_ff <= RADIX_DEC;
         acc_ff   <= '0;
         arr_ff   <= 1'b0;
         idx_ff   <= 1'b0;
         fail_ff  <= 1'b0;
         sat_ff   <= 1'b0;
      end else if (accept) begin
         gs_ff    <= gs_in;
         radix_ff <= radix_in;
         acc_ff   <= acc_in;
         arr_ff   <= arr_in;
         idx_ff   <= idx_in;
         fail_ff  <= fail_in;
         sat_ff   <= sat_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // check terms
   assign chk_mid_beat    = rsp_valid_ff && !rsp_data_ff.done_res;
   assign chk_mid_clear   = !rsp_data_ff.has_array && !rsp_data_ff.index_given
                            && rsp_data_ff.index_value == '0
                            && !rsp_data_ff.parse_fail && !rsp_data_ff.overflow;
   assign chk_last_taken  = rsp_valid_ff && rsp_data_ff.name_valid && rsp_data_ff.done_res;
   assign chk_state_start = gs_ff == GS_START && !fail_ff && !sat_ff && !arr_ff && !idx_ff;

   // checks
   `PETP_ASSERT_IMPLY(a_mid_summary_zero, chk_mid_beat, chk_mid_clear)
   `PETP_ASSERT_IMPLY(a_ovf_needs_index, rsp_valid_ff && rsp_data_ff.overflow, rsp_data_ff.index_given)
   `PETP_ASSERT_IMPLY(a_taken_no_fail, chk_last_taken, !rsp_data_ff.parse_fail)
   `PETP_ASSERT_NEXT(a_fail_sticky, fail_ff && !(accept && req_data.last), fail_ff)
   `PETP_ASSERT_NEXT(a_last_clears, accept && req_data.last, chk_state_start)

endmodule
